// ----- hdl/eutc_pkg.sv -----
// Shared types, constants and calendar tables for the epoch seconds to UTC calendar block.
package eutc_pkg;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } eutc_adv_t;

  localparam int unsigned SecsPerDay   = 86400;
  localparam int unsigned SecsPerHour  = 3600;
  localparam int unsigned SecsPerMin   = 60;
  localparam int unsigned MinsPerHour  = 60;
  localparam int unsigned DaysPerWeek  = 7;
  localparam int unsigned DaysPerQuad  = 1461;
  localparam int unsigned YearDays     = 365;
  localparam int unsigned EpochWeekday = 4;
  localparam int unsigned EpochYear    = 70;

  // floor(x / d) == (x * Mul) >> K for every x of the stated width
  localparam int unsigned     DayK   = 34;
  localparam longint unsigned DayDiv = SecsPerDay / 128;
  localparam logic [24:0]     DayMul = 25'(((64'd1 << DayK) + DayDiv - 1) / DayDiv);

  localparam int unsigned     QuadK   = 26;
  localparam longint unsigned QuadDiv = DaysPerQuad;
  localparam logic [15:0]     QuadMul = 16'(((64'd1 << QuadK) + QuadDiv - 1) / QuadDiv);

  localparam int unsigned     WeekK   = 18;
  localparam longint unsigned WeekDiv = DaysPerWeek;
  localparam logic [15:0]     WeekMul = 16'(((64'd1 << WeekK) + WeekDiv - 1) / WeekDiv);

  localparam int unsigned     HourK   = 21;
  localparam longint unsigned HourDiv = SecsPerHour / 16;
  localparam logic [13:0]     HourMul = 14'(((64'd1 << HourK) + HourDiv - 1) / HourDiv);

  localparam int unsigned     MinK   = 19;
  localparam longint unsigned MinDiv = SecsPerMin / 4;
  localparam logic [15:0]     MinMul = 16'(((64'd1 << MinK) + MinDiv - 1) / MinDiv);

  // first day of year of each month
  localparam logic [8:0] LeapFirst [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };
  localparam logic [8:0] CommonFirst [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

endpackage

// ----- hdl/eutc_day_split.sv -----
// Split of a seconds count into whole days and seconds of the day.
module eutc_day_split (
  input  logic                clk_i,
  input  eutc_pkg::eutc_adv_t adv_i,
  input  logic [30:0]         secs_i,
  output logic [14:0]         days_o,
  output logic [16:0]         sod_o
);

  logic [48:0] day_prod;
  logic [14:0] days_d, days_q;
  logic [30:0] secs_q;
  logic [16:0] sod_d, sod_q;

  assign day_prod = 49'(secs_i[30:7]) * 49'(eutc_pkg::DayMul);
  assign days_d   = day_prod[eutc_pkg::DayK +: 15];
  assign sod_d    = 17'(secs_q - 31'(days_q) * 31'(eutc_pkg::SecsPerDay));

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      days_q <= days_d;
      secs_q <= secs_i;
    end
    if (adv_i.s2) begin
      sod_q <= sod_d;
    end
  end

  assign days_o = days_q;
  assign sod_o  = sod_q;

endmodule

// ----- hdl/eutc_date.sv -----
// Date path: four-year cycle, year, day of year, month, day of month and weekday.
module eutc_date (
  input  logic                clk_i,
  input  eutc_pkg::eutc_adv_t adv_i,
  input  logic [14:0]         days_i,
  output logic [7:0]          year_o,
  output logic [8:0]          yday_o,
  output logic [3:0]          mon_o,
  output logic [4:0]          mday_o,
  output logic [2:0]          wday_o
);

  logic [30:0] quad_prod;
  logic [30:0] wk_prod;
  logic [14:0] wsum;
  logic [4:0]  quad_d, quad2_q, quad3_q;
  logic [11:0] q7_d, q7_q;
  logic [14:0] days2_q, wsum_q;
  logic [10:0] dq_d, dq_q;
  logic [2:0]  wd_d, wd_q, wd4_q;
  logic [1:0]  yiq;
  logic        leap;
  logic [8:0]  yday;
  logic [3:0]  mon_cnt;
  logic [8:0]  mon_first;
  logic [7:0]  year_d, year_q;
  logic [8:0]  yday_q;
  logic [3:0]  mon_q;
  logic [4:0]  mday_d, mday_q;

  assign quad_prod = 31'(days_i) * 31'(eutc_pkg::QuadMul);
  assign quad_d    = quad_prod[eutc_pkg::QuadK +: 5];
  assign wsum      = days_i + 15'(eutc_pkg::EpochWeekday);
  assign wk_prod   = 31'(wsum) * 31'(eutc_pkg::WeekMul);
  assign q7_d      = wk_prod[eutc_pkg::WeekK +: 12];

  assign dq_d = 11'(days2_q - 15'(quad2_q) * 15'(eutc_pkg::DaysPerQuad));
  assign wd_d = 3'(wsum_q - 15'(q7_q) * 15'(eutc_pkg::DaysPerWeek));

  always_comb begin
    if (dq_q < 11'(eutc_pkg::YearDays)) begin
      yiq  = 2'd0;
      leap = 1'b0;
      yday = 9'(dq_q);
    end else if (dq_q < 11'(2 * eutc_pkg::YearDays)) begin
      yiq  = 2'd1;
      leap = 1'b0;
      yday = 9'(dq_q - 11'(eutc_pkg::YearDays));
    end else if (dq_q < 11'(3 * eutc_pkg::YearDays + 1)) begin
      yiq  = 2'd2;
      leap = 1'b1;
      yday = 9'(dq_q - 11'(2 * eutc_pkg::YearDays));
    end else begin
      yiq  = 2'd3;
      leap = 1'b0;
      yday = 9'(dq_q - 11'(3 * eutc_pkg::YearDays + 1));
    end
  end

  always_comb begin
    mon_cnt = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if ((leap ? eutc_pkg::LeapFirst[m] : eutc_pkg::CommonFirst[m]) <= yday) begin
        mon_cnt = mon_cnt + 4'd1;
      end
    end
  end

  assign mon_first = leap ? eutc_pkg::LeapFirst[mon_cnt] : eutc_pkg::CommonFirst[mon_cnt];
  assign mday_d    = 5'(yday - mon_first + 9'd1);
  assign year_d    = 8'(eutc_pkg::EpochYear) + 8'({quad3_q, yiq});

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      quad2_q <= quad_d;
      q7_q    <= q7_d;
      days2_q <= days_i;
      wsum_q  <= wsum;
    end
    if (adv_i.s3) begin
      quad3_q <= quad2_q;
      dq_q    <= dq_d;
      wd_q    <= wd_d;
    end
    if (adv_i.s4) begin
      year_q <= year_d;
      yday_q <= yday;
      mon_q  <= mon_cnt;
      mday_q <= mday_d;
      wd4_q  <= wd_q;
    end
  end

  assign year_o = year_q;
  assign yday_o = yday_q;
  assign mon_o  = mon_q;
  assign mday_o = mday_q;
  assign wday_o = wd4_q;

endmodule

// ----- hdl/eutc_clock.sv -----
// Time-of-day path: hour, minute and second from the seconds of the day.
module eutc_clock (
  input  logic                clk_i,
  input  eutc_pkg::eutc_adv_t adv_i,
  input  logic [16:0]         sod_i,
  output logic [4:0]          hour_o,
  output logic [5:0]          minute_o,
  output logic [5:0]          second_o
);

  logic [26:0] hour_prod;
  logic [30:0] mt_prod;
  logic [4:0]  hour_d, hour_q, hour4_q;
  logic [10:0] mtot_d, mtot_q;
  logic [16:0] sod3_q;
  logic [5:0]  minute_d, minute_q;
  logic [5:0]  second_d, second_q;

  assign hour_prod = 27'(sod_i[16:4]) * 27'(eutc_pkg::HourMul);
  assign hour_d    = hour_prod[eutc_pkg::HourK +: 5];
  assign mt_prod   = 31'(sod_i[16:2]) * 31'(eutc_pkg::MinMul);
  assign mtot_d    = mt_prod[eutc_pkg::MinK +: 11];

  assign minute_d = 6'(mtot_q - 11'(hour_q) * 11'(eutc_pkg::MinsPerHour));
  assign second_d = 6'(sod3_q - 17'(mtot_q) * 17'(eutc_pkg::SecsPerMin));

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      hour_q <= hour_d;
      mtot_q <= mtot_d;
      sod3_q <= sod_i;
    end
    if (adv_i.s4) begin
      hour4_q  <= hour_q;
      minute_q <= minute_d;
      second_q <= second_d;
    end
  end

  assign hour_o   = hour4_q;
  assign minute_o = minute_q;
  assign second_o = second_q;

endmodule

// ----- hdl/epoch_seconds_to_utc_calendar.sv -----
// Top level of the epoch seconds to UTC calendar converter.
//
// Slave channel s_axis_*: one item per count of seconds since 1970-01-01 UTC.
// Master channel m_axis_*: one broken-down UTC time per input item, in order.
// An item moves at a rising edge with tvalid and tready both high.
//
// The block is a five-register pipeline: input register, day split,
// reciprocal quotients (four-year cycle, weekday, hour, minute total),
// remainders, and the result register that drives m_axis_tdata_o.
// An accepted item passes through these five registers in order before
// it shows on the master side. Throughput: one item per cycle while the
// master side takes results without stalling.
//
// Each stage advances when empty or when the next stage advances, so a
// stalled receiver holds the result register while empty stages behind
// it keep taking items; s_axis_tready_o drops only once all stages hold
// items. Reset empties the pipeline; payload registers are not reset.
module epoch_seconds_to_utc_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [30:0] epoch_seconds, [31] zero
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] years_since_1900, [16:8] day_of_year, [20:17] month_index,
  // [25:21] day_of_month, [28:26] weekday, [33:29] hour_of_day,
  // [39:34] minute_of_hour, [45:40] second_of_minute, [47:46] zero
  output logic [47:0] m_axis_tdata_o
);

  logic [4:0]          vld_d, vld_q;
  logic [4:0]          adv;
  eutc_pkg::eutc_adv_t adv_s;
  logic [30:0]         secs_q;
  logic [14:0]         days;
  logic [16:0]         sod;
  logic [7:0]          year;
  logic [8:0]          yday;
  logic [3:0]          mon;
  logic [4:0]          mday;
  logic [2:0]          wday;
  logic [4:0]          hour;
  logic [5:0]          minute;
  logic [5:0]          second;

  assign adv[4] = !vld_q[4] || m_axis_tready_i;
  assign adv[3] = !vld_q[3] || adv[4];
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];

  assign adv_s.s1 = adv[1];
  assign adv_s.s2 = adv[2];
  assign adv_s.s3 = adv[3];
  assign adv_s.s4 = adv[4];

  assign vld_d[0] = adv[0] ? s_axis_tvalid_i : vld_q[0];
  assign vld_d[1] = adv[1] ? vld_q[0] : vld_q[1];
  assign vld_d[2] = adv[2] ? vld_q[1] : vld_q[2];
  assign vld_d[3] = adv[3] ? vld_q[2] : vld_q[3];
  assign vld_d[4] = adv[4] ? vld_q[3] : vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      secs_q <= s_axis_tdata_i[30:0];
    end
  end

  eutc_day_split u_day_split (
    .clk_i  (clk_i),
    .adv_i  (adv_s),
    .secs_i (secs_q),
    .days_o (days),
    .sod_o  (sod)
  );

  eutc_date u_date (
    .clk_i  (clk_i),
    .adv_i  (adv_s),
    .days_i (days),
    .year_o (year),
    .yday_o (yday),
    .mon_o  (mon),
    .mday_o (mday),
    .wday_o (wday)
  );

  eutc_clock u_clock (
    .clk_i    (clk_i),
    .adv_i    (adv_s),
    .sod_i    (sod),
    .hour_o   (hour),
    .minute_o (minute),
    .second_o (second)
  );

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = vld_q[4];
  assign m_axis_tdata_o  = {2'b00, second, minute, hour, wday, mday, mon, yday, year};

  a_month_day : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (mon < 4'd12) && (mday != 5'd0))
    else $error("month or day of month out of range");

  a_year_yday : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (year >= 8'd70) && (year <= 8'd138) && (yday <= 9'd365))
    else $error("year or day of year out of range");

  a_wday_hour : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (wday < 3'd7) && (hour < 5'd24))
    else $error("weekday or hour out of range");

  a_min_sec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (minute < 6'd60) && (second < 6'd60))
    else $error("minute or second out of range");

  a_accept_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted item missing from input stage");

endmodule
